### rtl/npis_pkg.sv
// Shared types, codes, constants and tables of the nearest point in sector unit.
package npis_pkg;

    localparam int COORD_WIDTH_DEF  = 18;
    localparam int ANGLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int NUM_REGS  = 7;
    localparam int CFG_AW    = 5;

    localparam logic [2:0] REG_TARGET_ANGLE = 3'd0;
    localparam logic [2:0] REG_AZIMUTH_TOL  = 3'd1;
    localparam logic [2:0] REG_MIN_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_MAX_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_MIN_DISTANCE = 3'd4;
    localparam logic [2:0] REG_MAX_DISTANCE = 3'd5;
    localparam logic [2:0] REG_SAFETY_MARGIN = 3'd6;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_NO_RANGE = 2'd1;
    localparam logic [1:0] ST_FOUND    = 2'd2;

    localparam logic [31:0] TWO_PI_2P28 = 32'h6487ED51;
    localparam logic [63:0] PI_2P40     = 64'h0000_0324_3F6A_8885;
    localparam logic signed [33:0] HALF_TURN = 34'sh0_8000_0000;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CORD_PT,
        OP_CORD_BEST,
        OP_CORD_STEP,
        OP_MUL_ANG,
        OP_ANG,
        OP_MUL_X2,
        OP_MUL_Y2,
        OP_MUL_MIN,
        OP_MUL_MAX,
        OP_EVAL,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SQRT_FIX,
        OP_TD,
        OP_MUL_TDX,
        OP_MUL_TDY,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END_X,
        OP_DIV_END_Y,
        OP_REPORT
    } op_t;

    function automatic logic [63:0] pi_q(input int aw);
        int sh;
        sh = 43 - aw;
        return (PI_2P40 + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [63:0] two_pi_q(input int aw);
        int sh;
        sh = 42 - aw;
        return (PI_2P40 + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

### rtl/nearest_point_in_sector_unit.sv
// Top level of the nearest point in sector unit: stream ports, APB registers, controller, datapath.
// A point with point_valid low is only loaded and runs no bearing or window test. A valid point
// runs the iterative CORDIC bearing unit, then passes through the single shared multiplier for
// the angle scale, the squared coordinates and the squared distance bounds, then one evaluation
// step. On the last point of a scan with a point found, the report first runs a one-bit-per-cycle
// square root, two one-bit-per-cycle divisions and a second CORDIC run for the yaw. The result
// waits in an output register, so the next scan can start while it is still held on the master side.
module nearest_point_in_sector_unit
    import npis_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // point_x, point_y, point_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]            s_tdata,
    // point_valid
    input  logic                                          s_tuser,
    input  logic                                          s_tlast,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // goal_x, goal_y, goal_yaw
    output logic [((2*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] m_tdata,
    // status, rotate_only
    output logic [2:0]                                    m_tuser,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [CFG_AW-1:0]                             paddr,
    input  logic [31:0]                                   pwdata,
    output logic [31:0]                                   prdata,
    output logic                                          pready
);

    localparam int MAXN  = (CORDIC_STEPS > COORD_WIDTH) ? CORDIC_STEPS : COORD_WIDTH;
    localparam int CNT_W = $clog2(MAXN + 1);
    localparam int OUT_W = ((2*COORD_WIDTH+ANGLE_WIDTH+7)/8)*8;

    logic signed [ANGLE_WIDTH-1:0] target_angle;
    logic [ANGLE_WIDTH-2:0]        sector_half_width;
    logic signed [17:0]            min_height, max_height;
    logic [17:0]                   min_distance, max_distance, safety_margin;
    op_t                           op;
    logic [CNT_W-1:0]              step;
    logic                          found;
    logic [1:0]                    status;
    logic [COORD_WIDTH-1:0]        goal_x, goal_y;
    logic [ANGLE_WIDTH-1:0]        goal_yaw;
    logic                          rotate_only;

    assign pready  = 1'b1;
    assign m_tdata = OUT_W'({goal_yaw, goal_y, goal_x});
    assign m_tuser = {rotate_only, status};

    npis_cfg #(
        .ANGLE_WIDTH(ANGLE_WIDTH)
    ) u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .target_angle      (target_angle),
        .sector_half_width (sector_half_width),
        .min_height        (min_height),
        .max_height        (max_height),
        .min_distance      (min_distance),
        .max_distance      (max_distance),
        .safety_margin     (safety_margin)
    );

    npis_ctrl #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .found    (found),
        .op       (op),
        .step     (step)
    );

    npis_datapath #(
        .COORD_WIDTH  (COORD_WIDTH),
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .op                (op),
        .step              (step),
        .in_x              (s_tdata[COORD_WIDTH-1:0]),
        .in_y              (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .in_z              (s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .target_angle      (target_angle),
        .sector_half_width (sector_half_width),
        .min_height        (min_height),
        .max_height        (max_height),
        .min_distance      (min_distance),
        .max_distance      (max_distance),
        .safety_margin     (safety_margin),
        .found             (found),
        .status            (status),
        .goal_x            (goal_x),
        .goal_y            (goal_y),
        .goal_yaw          (goal_yaw),
        .rotate_only       (rotate_only)
    );

endmodule

### rtl/npis_cfg.sv
// Configuration register file behind the APB-style port.
module npis_cfg
    import npis_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_AW-1:0]             paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic signed [ANGLE_WIDTH-1:0] target_angle,
    output logic [ANGLE_WIDTH-2:0]        sector_half_width,
    output logic signed [17:0]            min_height,
    output logic signed [17:0]            max_height,
    output logic [17:0]                   min_distance,
    output logic [17:0]                   max_distance,
    output logic [17:0]                   safety_margin
);

    logic [2:0] idx;
    logic       wr;

    assign idx = paddr[4:2];
    assign wr  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_angle      <= '0;
            sector_half_width <= (ANGLE_WIDTH-1)'(1638);
            min_height        <= 18'sd0;
            max_height        <= 18'sd2000;
            min_distance      <= 18'd500;
            max_distance      <= 18'd10000;
            safety_margin     <= 18'd1250;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_TARGET_ANGLE:  target_angle      <= pwdata[ANGLE_WIDTH-1:0];
                REG_AZIMUTH_TOL:   sector_half_width <= pwdata[ANGLE_WIDTH-2:0];
                REG_MIN_HEIGHT:    min_height        <= pwdata[17:0];
                REG_MAX_HEIGHT:    max_height        <= pwdata[17:0];
                REG_MIN_DISTANCE:  min_distance      <= pwdata[17:0];
                REG_MAX_DISTANCE:  max_distance      <= pwdata[17:0];
                REG_SAFETY_MARGIN: safety_margin     <= pwdata[17:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TARGET_ANGLE:  prdata = 32'(target_angle[ANGLE_WIDTH-1:0]);
            REG_AZIMUTH_TOL:   prdata = 32'(sector_half_width);
            REG_MIN_HEIGHT:    prdata = 32'(min_height[17:0]);
            REG_MAX_HEIGHT:    prdata = 32'(max_height[17:0]);
            REG_MIN_DISTANCE:  prdata = 32'(min_distance);
            REG_MAX_DISTANCE:  prdata = 32'(max_distance);
            REG_SAFETY_MARGIN: prdata = 32'(safety_margin);
            default:           prdata = 32'd0;
        endcase
    end

endmodule

### rtl/npis_ctrl.sv
// Controller state machine that sequences the datapath for each point and report.
module npis_ctrl
    import npis_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    localparam int MAXN  = (CORDIC_STEPS > COORD_WIDTH) ? CORDIC_STEPS : COORD_WIDTH,
    localparam int CNT_W = $clog2(MAXN + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tuser,
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  logic             found,
    output op_t              op,
    output logic [CNT_W-1:0] step
);

    typedef enum logic [4:0] {
        S_IDLE, S_CINIT, S_CSTEP, S_MANG, S_ANG, S_MX2, S_MY2, S_MMN, S_MMX,
        S_EVAL, S_FINISH, S_SQI, S_SQS, S_SQF, S_TD, S_MTX, S_MTY, S_DI, S_DS,
        S_DE, S_REPORT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             final_reg, final_next;
    logic             ysel_reg, ysel_next;
    logic             mv_reg, mv_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign step     = cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        final_next = final_reg;
        ysel_next  = ysel_reg;
        mv_next    = (mv_reg && m_tready) ? 1'b0 : mv_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op         = OP_LOAD;
                    last_next  = s_tlast;
                    final_next = 1'b0;
                    ysel_next  = 1'b0;
                    if (s_tuser)
                        state_next = S_CINIT;
                    else if (s_tlast)
                        state_next = S_FINISH;
                end
            end
            S_CINIT:
            begin
                op         = final_reg ? OP_CORD_BEST : OP_CORD_PT;
                cnt_next   = '0;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                op       = OP_CORD_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = S_MANG;
            end
            S_MANG:
            begin
                op         = OP_MUL_ANG;
                state_next = S_ANG;
            end
            S_ANG:
            begin
                op         = OP_ANG;
                state_next = final_reg ? S_REPORT : S_MX2;
            end
            S_MX2:
            begin
                op         = OP_MUL_X2;
                state_next = S_MY2;
            end
            S_MY2:
            begin
                op         = OP_MUL_Y2;
                state_next = S_MMN;
            end
            S_MMN:
            begin
                op         = OP_MUL_MIN;
                state_next = S_MMX;
            end
            S_MMX:
            begin
                op         = OP_MUL_MAX;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                op         = OP_EVAL;
                state_next = last_reg ? S_FINISH : S_IDLE;
            end
            S_FINISH:
            begin
                state_next = found ? S_SQI : S_REPORT;
            end
            S_SQI:
            begin
                op         = OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQS;
            end
            S_SQS:
            begin
                op       = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COORD_WIDTH - 1))
                    state_next = S_SQF;
            end
            S_SQF:
            begin
                op         = OP_SQRT_FIX;
                state_next = S_TD;
            end
            S_TD:
            begin
                op         = OP_TD;
                state_next = S_MTX;
            end
            S_MTX:
            begin
                op         = OP_MUL_TDX;
                state_next = S_DI;
            end
            S_MTY:
            begin
                op         = OP_MUL_TDY;
                state_next = S_DI;
            end
            S_DI:
            begin
                op         = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DS;
            end
            S_DS:
            begin
                op       = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COORD_WIDTH - 1))
                    state_next = S_DE;
            end
            S_DE:
            begin
                if (ysel_reg)
                begin
                    op         = OP_DIV_END_Y;
                    final_next = 1'b1;
                    state_next = S_CINIT;
                end
                else
                begin
                    op         = OP_DIV_END_X;
                    ysel_next  = 1'b1;
                    state_next = S_MTY;
                end
            end
            S_REPORT:
            begin
                if (!mv_reg || m_tready)
                begin
                    op         = OP_REPORT;
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            final_reg <= 1'b0;
            ysel_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            final_reg <= final_next;
            ysel_reg  <= ysel_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

### rtl/npis_datapath.sv
// Datapath: CORDIC bearing, shared multiplier, window tests, square root, divider, result.
module npis_datapath
    import npis_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    localparam int MAXN  = (CORDIC_STEPS > COORD_WIDTH) ? CORDIC_STEPS : COORD_WIDTH,
    localparam int CNT_W = $clog2(MAXN + 1)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  op_t                           op,
    input  logic [CNT_W-1:0]              step,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    input  logic signed [ANGLE_WIDTH-1:0] target_angle,
    input  logic [ANGLE_WIDTH-2:0]        sector_half_width,
    input  logic signed [17:0]            min_height,
    input  logic signed [17:0]            max_height,
    input  logic [17:0]                   min_distance,
    input  logic [17:0]                   max_distance,
    input  logic [17:0]                   safety_margin,
    output logic                          found,
    output logic [1:0]                    status,
    output logic [COORD_WIDTH-1:0]        goal_x,
    output logic [COORD_WIDTH-1:0]        goal_y,
    output logic [ANGLE_WIDTH-1:0]        goal_yaw,
    output logic                          rotate_only
);

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = ANGLE_WIDTH;
    localparam int XW  = CW + 3;
    localparam int ZW  = 34;
    localparam int PW  = 66;
    localparam int HW  = (CW > 18) ? CW : 18;
    localparam int SQW = 2 * CW;
    localparam int DSW = (SQW > 36) ? SQW : 36;
    localparam int DFW = AW + 2;
    localparam int SH  = 63 - AW;
    localparam logic [63:0] PIQ = pi_q(AW);
    localparam logic [63:0] TPQ = two_pi_q(AW);
    localparam logic signed [DFW-1:0] P_S  = DFW'(PIQ);
    localparam logic signed [DFW-1:0] TP_S = DFW'(TPQ);

    logic signed [CW-1:0]  px_reg, py_reg, pz_reg;
    logic [CW-1:0]         pax_reg, pay_reg;
    logic signed [CW-1:0]  bx_reg, by_reg;
    logic [CW-1:0]         bax_reg, bay_reg;
    logic [SQW-1:0]        bdsq_reg;
    logic                  any_reg, found_reg;
    logic signed [XW-1:0]  cx_reg, cy_reg;
    logic signed [ZW-1:0]  cz_reg;
    logic [PW-1:0]         prod_reg;
    logic [SQW-1:0]        acc_reg;
    logic [35:0]           mnsq_reg;
    logic signed [AW-1:0]  ang_reg;
    logic [SQW-1:0]        srem_reg, sroot_reg, sbit_reg;
    logic [CW-1:0]         g_reg, td_reg;
    logic [CW-1:0]         drem_reg, dq_reg;
    logic [CW-1:0]         gx_reg, gy_reg;
    logic [1:0]            status_reg;
    logic [CW-1:0]         ox_reg, oy_reg;
    logic [AW-1:0]         oyaw_reg;
    logic                  orot_reg;

    logic [ZW-1:0]         mul_a;
    logic [31:0]           mul_b;
    logic signed [XW-1:0]  sx, sy, dx, dy;
    logic signed [ZW-1:0]  at;
    logic [ZW-1:0]         zmag;
    logic [PW-1:0]         qv;
    logic [AW-1:0]         qc;
    logic signed [DFW-1:0] dif;
    logic [DFW-1:0]        adif;
    logic signed [HW-1:0]  zh, minh, maxh;
    logic                  keep_sec, keep_rng;
    logic [SQW-1:0]        sq_t;
    logic [HW-1:0]         g_e, sm_e;
    logic [SQW-1:0]        num;
    logic [CW:0]           dt;
    logic                  dge;
    logic [CW-1:0]         qsel;

    assign found       = found_reg;
    assign status      = status_reg;
    assign goal_x      = ox_reg;
    assign goal_y      = oy_reg;
    assign goal_yaw    = oyaw_reg;
    assign rotate_only = orot_reg;

    assign zmag = cz_reg[ZW-1] ? ZW'(-cz_reg) : ZW'(cz_reg);
    assign dx   = cy_reg >>> step;
    assign dy   = cx_reg >>> step;
    assign at   = $signed({2'b00, atan_turns(5'(step))});
    assign sx   = (op == OP_CORD_BEST) ? XW'(bx_reg) : XW'(px_reg);
    assign sy   = (op == OP_CORD_BEST) ? XW'(by_reg) : XW'(py_reg);

    assign qv   = (prod_reg + (PW'(1) << (SH - 1))) >> SH;
    assign qc   = (qv > PW'(PIQ)) ? AW'(PIQ) : AW'(qv);

    always_comb
    begin
        unique case (op)
            OP_MUL_ANG:
            begin
                mul_a = zmag;
                mul_b = TWO_PI_2P28;
            end
            OP_MUL_X2:
            begin
                mul_a = ZW'(pax_reg);
                mul_b = 32'(pax_reg);
            end
            OP_MUL_Y2:
            begin
                mul_a = ZW'(pay_reg);
                mul_b = 32'(pay_reg);
            end
            OP_MUL_MIN:
            begin
                mul_a = ZW'(min_distance);
                mul_b = 32'(min_distance);
            end
            OP_MUL_MAX:
            begin
                mul_a = ZW'(max_distance);
                mul_b = 32'(max_distance);
            end
            OP_MUL_TDX:
            begin
                mul_a = ZW'(td_reg);
                mul_b = 32'(bax_reg);
            end
            OP_MUL_TDY:
            begin
                mul_a = ZW'(td_reg);
                mul_b = 32'(bay_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        dif = DFW'(ang_reg) - DFW'(target_angle);
        for (int k = 0; k < 2; k++)
        begin
            if (dif > P_S)
                dif = dif - TP_S;
            else if (dif <= -P_S)
                dif = dif + TP_S;
        end
        adif = dif[DFW-1] ? DFW'(-dif) : DFW'(dif);
    end

    assign zh       = HW'(pz_reg);
    assign minh     = HW'(min_height);
    assign maxh     = HW'(max_height);
    assign keep_sec = (adif < DFW'(sector_half_width)) && (zh > minh) && (zh < maxh);
    assign keep_rng = (DSW'(acc_reg) > DSW'(mnsq_reg)) && (DSW'(acc_reg) < DSW'(prod_reg[35:0]));

    assign sq_t = sroot_reg + sbit_reg;
    assign g_e  = HW'(g_reg);
    assign sm_e = HW'(safety_margin);
    assign num  = prod_reg[SQW-1:0] + SQW'(g_reg >> 1);
    assign dt   = {drem_reg, dq_reg[CW-1]};
    assign dge  = dt >= {1'b0, g_reg};
    assign qsel = (g_reg == '0) ? '0 : dq_reg;

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                px_reg  <= in_x;
                py_reg  <= in_y;
                pz_reg  <= in_z;
                pax_reg <= in_x[CW-1] ? CW'(-in_x) : CW'(in_x);
                pay_reg <= in_y[CW-1] ? CW'(-in_y) : CW'(in_y);
            end
            OP_CORD_PT, OP_CORD_BEST:
            begin
                if (sx < 0)
                begin
                    cx_reg <= -sx;
                    cy_reg <= -sy;
                    cz_reg <= (sy >= 0) ? HALF_TURN : -HALF_TURN;
                end
                else
                begin
                    cx_reg <= sx;
                    cy_reg <= sy;
                    cz_reg <= '0;
                end
            end
            OP_CORD_STEP:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + at;
                end
                else if (cy_reg < 0)
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - at;
                end
            end
            OP_ANG:
            begin
                ang_reg <= cz_reg[ZW-1] ? AW'(-qc) : AW'(qc);
            end
            OP_MUL_Y2:
            begin
                acc_reg <= prod_reg[SQW-1:0];
            end
            OP_MUL_MIN:
            begin
                acc_reg <= acc_reg + prod_reg[SQW-1:0];
            end
            OP_MUL_MAX:
            begin
                mnsq_reg <= prod_reg[35:0];
            end
            OP_SQRT_INIT:
            begin
                srem_reg  <= bdsq_reg;
                sroot_reg <= '0;
                sbit_reg  <= SQW'(1) << (SQW - 2);
            end
            OP_SQRT_STEP:
            begin
                if (srem_reg >= sq_t)
                begin
                    srem_reg  <= srem_reg - sq_t;
                    sroot_reg <= (sroot_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sroot_reg <= sroot_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            OP_SQRT_FIX:
            begin
                g_reg <= (srem_reg > sroot_reg) ? CW'(sroot_reg + 1'b1) : CW'(sroot_reg);
            end
            OP_TD:
            begin
                td_reg <= (g_e > sm_e) ? CW'(g_e - sm_e) : '0;
            end
            OP_DIV_INIT:
            begin
                drem_reg <= num[SQW-1:CW];
                dq_reg   <= num[CW-1:0];
            end
            OP_DIV_STEP:
            begin
                drem_reg <= dge ? CW'(dt - {1'b0, g_reg}) : CW'(dt);
                dq_reg   <= {dq_reg[CW-2:0], dge};
            end
            OP_DIV_END_X:
            begin
                gx_reg <= bx_reg[CW-1] ? CW'(-qsel) : qsel;
            end
            OP_DIV_END_Y:
            begin
                gy_reg <= by_reg[CW-1] ? CW'(-qsel) : qsel;
            end
            default:
            begin
            end
        endcase
        if (op == OP_MUL_ANG || op == OP_MUL_X2 || op == OP_MUL_Y2 || op == OP_MUL_MIN ||
            op == OP_MUL_MAX || op == OP_MUL_TDX || op == OP_MUL_TDY)
        begin
            prod_reg <= mul_a * PW'(mul_b);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bx_reg     <= '0;
            by_reg     <= '0;
            bax_reg    <= '0;
            bay_reg    <= '0;
            bdsq_reg   <= '1;
            any_reg    <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= ST_NONE;
            ox_reg     <= '0;
            oy_reg     <= '0;
            oyaw_reg   <= '0;
            orot_reg   <= 1'b0;
        end
        else if (op == OP_EVAL)
        begin
            if (keep_sec)
            begin
                any_reg <= 1'b1;
                if (keep_rng)
                begin
                    found_reg <= 1'b1;
                    if (acc_reg < bdsq_reg)
                    begin
                        bdsq_reg <= acc_reg;
                        bx_reg   <= px_reg;
                        by_reg   <= py_reg;
                        bax_reg  <= pax_reg;
                        bay_reg  <= pay_reg;
                    end
                end
            end
        end
        else if (op == OP_REPORT)
        begin
            priority if (found_reg)
            begin
                status_reg <= ST_FOUND;
                ox_reg     <= gx_reg;
                oy_reg     <= gy_reg;
                oyaw_reg   <= ang_reg;
                orot_reg   <= (gx_reg == '0) && (gy_reg == '0);
            end
            else
            begin
                status_reg <= any_reg ? ST_NO_RANGE : ST_NONE;
                ox_reg     <= '0;
                oy_reg     <= '0;
                oyaw_reg   <= '0;
                orot_reg   <= 1'b0;
            end
            bx_reg    <= '0;
            by_reg    <= '0;
            bax_reg   <= '0;
            bay_reg   <= '0;
            bdsq_reg  <= '1;
            any_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
    end

    a_no_best_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !found_reg |-> bdsq_reg == '1)
        else $error("best distance set without a point in range");

    a_found_implies_sector: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> any_reg)
        else $error("point in range without point in sector");

    a_rotate_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        orot_reg |-> status_reg == ST_FOUND)
        else $error("rotate flag without a found point");

    a_report_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_REPORT) |=> (!found_reg && !any_reg))
        else $error("scan state not cleared after report");

endmodule

### dv/tb_nearest_point_in_sector_unit.sv
// Self-checking testbench of the nearest point in sector unit: stream driver, monitor, scan predictor.
module tb_nearest_point_in_sector_unit;
    import npis_pkg::*;

    localparam int CW = 18;
    localparam int AW = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE = 200;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 valid;
        logic                 last;
    } point_t;

    typedef struct {
        logic [1:0]           status;
        logic signed [CW-1:0] gx;
        logic signed [CW-1:0] gy;
        logic signed [AW-1:0] yaw;
        logic                 rot;
    } goal_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    nearest_point_in_sector_unit dut (.*);

    always #2 clk = ~clk;

    // register copies
    logic signed [AW-1:0] cfg_target;
    logic [AW-2:0]        cfg_tol;
    logic signed [17:0]   cfg_min_h;
    logic signed [17:0]   cfg_max_h;
    logic [17:0]          cfg_min_d;
    logic [17:0]          cfg_max_d;
    logic [17:0]          cfg_margin;

    // scan state
    longint               best_x;
    longint               best_y;
    longint unsigned      best_dsq;
    bit                   any_in_sector;
    bit                   found_in_range;

    longint atan_tab [0:15] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    point_t pending_points[$];
    goal_t  expected_goals[$];
    point_t cur_point;
    bit     in_hs = 0;
    int     idle_mode = 0;
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     points_sent = 0;
    int     goals_seen = 0;
    int     found_seen = 0;

    function automatic longint pi_units();
        return longint'((64'h3243F6A8885 + (64'd1 << 26)) >> 27);
    endfunction

    function automatic longint two_pi_units();
        return longint'((64'h3243F6A8885 + (64'd1 << 25)) >> 26);
    endfunction

    function automatic longint calc_bearing(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        longint unsigned m;
        longint q;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_tab[i];
            end
            else if (y < 0)
            begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
        end
        m = (z < 0) ? longint'(-z) : longint'(z);
        q = longint'((m * 64'h6487ED51 + (64'd1 << 46)) >> 47);
        if (q > pi_units())
            q = pi_units();
        return (z < 0) ? -q : q;
    endfunction

    function automatic longint unsigned round_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned rem;
        r = 0;
        b = 64'd1 << 62;
        rem = v;
        while (b > rem)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= r + b)
            begin
                rem -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        if (v - r * r > r)
            r++;
        return r;
    endfunction

    function automatic longint scale_goal(longint unsigned td, longint c, longint unsigned g);
        longint unsigned m;
        longint unsigned q;
        if (g == 0)
            return 0;
        m = (c < 0) ? longint'(-c) : longint'(c);
        q = (td * m + g / 2) / g;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic clear_scan();
        best_x = 0;
        best_y = 0;
        best_dsq = '1;
        any_in_sector = 0;
        found_in_range = 0;
    endtask

    task automatic predict_point(point_t p);
        longint x;
        longint y;
        longint z;
        longint diff;
        longint unsigned dsq;
        longint unsigned g;
        longint unsigned td;
        longint sx;
        longint sy;
        goal_t r;
        x = p.x;
        y = p.y;
        z = p.z;
        if (p.valid)
        begin
            diff = calc_bearing(x, y) - longint'(cfg_target);
            for (int k = 0; k < 2; k++)
            begin
                if (diff > pi_units())
                    diff -= two_pi_units();
                else if (diff <= -pi_units())
                    diff += two_pi_units();
            end
            if (diff < 0)
                diff = -diff;
            if (diff < longint'(cfg_tol) && z > longint'(cfg_min_h) && z < longint'(cfg_max_h))
            begin
                dsq = x * x + y * y;
                any_in_sector = 1;
                if (dsq > longint'(cfg_min_d) * longint'(cfg_min_d)
                    && dsq < longint'(cfg_max_d) * longint'(cfg_max_d))
                begin
                    found_in_range = 1;
                    if (dsq < best_dsq)
                    begin
                        best_dsq = dsq;
                        best_x = x;
                        best_y = y;
                    end
                end
            end
        end
        if (!p.last)
            return;
        r = '{ST_NONE, 0, 0, 0, 0};
        if (found_in_range)
        begin
            g = round_sqrt(best_dsq);
            td = (g > cfg_margin) ? g - cfg_margin : 0;
            sx = scale_goal(td, best_x, g);
            sy = scale_goal(td, best_y, g);
            r.status = ST_FOUND;
            r.gx = sx[CW-1:0];
            r.gy = sy[CW-1:0];
            r.yaw = AW'(calc_bearing(best_x, best_y));
            r.rot = (sx == 0 && sy == 0);
        end
        else if (any_in_sector)
            r.status = ST_NO_RANGE;
        expected_goals.push_back(r);
        clear_scan();
    endtask

    // input side: accept at rising edge, load next transaction at falling edge
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            predict_point(cur_point);
            points_sent++;
            in_hs = 1;
        end
    end

    always @(negedge clk)
    begin
        if (!s_tvalid || in_hs)
        begin
            in_hs = 0;
            if (pending_points.size() > 0
                && !((idle_mode == 1 && $urandom_range(99) < 68)
                     || (idle_mode == 3 && $urandom_range(99) < 9)))
            begin
                cur_point = pending_points.pop_front();
                s_tvalid <= 1;
                s_tdata <= {2'b00, cur_point.z, cur_point.y, cur_point.x};
                s_tuser <= cur_point.valid;
                s_tlast <= cur_point.last;
            end
            else
                s_tvalid <= 0;
        end
        m_tready <= !((idle_mode == 2 && $urandom_range(99) < 68)
                      || (idle_mode == 3 && $urandom_range(99) < 9));
    end

    // output side: check each transaction against the oldest expected goal
    always @(posedge clk)
    begin
        goal_t e;
        goal_t a;
        if (m_tvalid && m_tready)
        begin
            a.gx = m_tdata[17:0];
            a.gy = m_tdata[35:18];
            a.yaw = m_tdata[51:36];
            a.status = m_tuser[1:0];
            a.rot = m_tuser[2];
            goals_seen++;
            if (expected_goals.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected goal: status %0d", a.status);
            end
            else
            begin
                e = expected_goals.pop_front();
                if (e.status == ST_FOUND)
                    found_seen++;
                if (a.status != e.status || a.gx != e.gx || a.gy != e.gy
                    || a.yaw != e.yaw || a.rot != e.rot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("goal mismatch: exp st %0d x %0d y %0d yaw %0d rot %0d",
                                 e.status, e.gx, e.gy, e.yaw, e.rot);
                        $display("               got st %0d x %0d y %0d yaw %0d rot %0d",
                                 a.status, a.gx, a.gy, a.yaw, a.rot);
                    end
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic set_config(int ta, int tol, int minh, int maxh, int mind, int maxd, int sm);
        cfg_target = AW'(ta);
        cfg_tol = (AW-1)'(tol);
        cfg_min_h = 18'(minh);
        cfg_max_h = 18'(maxh);
        cfg_min_d = 18'(mind);
        cfg_max_d = 18'(maxd);
        cfg_margin = 18'(sm);
        apb_write(REG_TARGET_ANGLE, ta);
        apb_write(REG_AZIMUTH_TOL, tol);
        apb_write(REG_MIN_HEIGHT, minh);
        apb_write(REG_MAX_HEIGHT, maxh);
        apb_write(REG_MIN_DISTANCE, mind);
        apb_write(REG_MAX_DISTANCE, maxd);
        apb_write(REG_SAFETY_MARGIN, sm);
    endtask

    task automatic add_point(int x, int y, int z, bit v, bit l);
        point_t p;
        p.x = CW'(x);
        p.y = CW'(y);
        p.z = CW'(z);
        p.valid = v;
        p.last = l;
        pending_points.push_back(p);
    endtask

    function automatic int clamp_coord(real v);
        if (v > 131071.0)
            return 131071;
        if (v < -131072.0)
            return -131072;
        return $rtoi(v);
    endfunction

    task automatic add_scans(int n_items);
        int len;
        int count;
        real ang;
        real r;
        int h;
        count = 0;
        while (count < n_items)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < 80)
                begin
                    ang = real'(cfg_target) / 8192.0
                          + (real'($urandom_range(2000)) - 1000.0) / 1000.0
                            * (real'(cfg_tol) / 8192.0) * 1.3;
                    r = real'(cfg_min_d) + (real'($urandom_range(100000)) / 100000.0)
                        * real'(int'(cfg_max_d) - int'(cfg_min_d) + 200) - 100.0;
                    if ($urandom_range(3) == 0)
                        h = $urandom_range(262143) - 131072;
                    else
                        h = int'(cfg_min_h) + $urandom_range(2000) - 200;
                    add_point(clamp_coord(r * $cos(ang)), clamp_coord(r * $sin(ang)), h,
                              $urandom_range(99) < 95, i == len - 1);
                end
                else
                    add_point($urandom_range(262143) - 131072, $urandom_range(262143) - 131072,
                              $urandom_range(262143) - 131072, $urandom_range(1) == 1,
                              i == len - 1);
            end
            count += len;
        end
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || expected_goals.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        cfg_target = 0;
        cfg_tol = 1638;
        cfg_min_h = 0;
        cfg_max_h = 2000;
        cfg_min_d = 500;
        cfg_max_d = 10000;
        cfg_margin = 1250;
        clear_scan();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed scans at reset settings
        add_point(1000, 0, 100, 1, 1);
        add_point(0, 0, 100, 1, 1);
        add_point(1000, 0, 100, 0, 1);
        add_point(3000, 0, 100, 1, 0);
        add_point(2000, 0, 100, 0, 1);
        add_point(-131072, 0, 100, 1, 1);
        add_point(131071, 131071, 131071, 1, 1);
        add_point(-131072, -131072, -131072, 1, 1);
        add_point(2000, 0, 0, 1, 0);
        add_point(2000, 0, 1999, 1, 1);
        add_point(500, 0, 100, 1, 0);
        add_point(10000, 0, 100, 1, 1);
        add_point(3000, 100, 100, 1, 0);
        add_point(3000, -100, 100, 1, 0);
        add_point(5000, 0, 100, 1, 1);
        add_point(1200, 0, 100, 1, 1);
        add_point(1250, 0, 500, 1, 1);
        add_point(9999, 500, 1, 1, 1);
        add_point(501, 0, 1, 1, 1);
        add_point(4000, -600, 100, 1, 0);
        add_point(-4000, 600, 100, 1, 1);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            idle_mode = ph % 4;
            case (ph)
                0: set_config(25736, 25736, -131072, 131071, 0, 185363, 0);
                1: set_config(-25736, 0, 131071, -131072, 185363, 0, 185363);
                2: set_config(-25736, 3000, -1000, 3000, 0, 185363, 185363);
                3: set_config(25736, 2000, -131072, 131071, 1000, 185363, 0);
                default: set_config($urandom_range(51472) - 25736, $urandom_range(6000),
                                    $urandom_range(1000) - 500, $urandom_range(3000) + 1000,
                                    $urandom_range(2000), $urandom_range(150000, 3000),
                                    $urandom_range(5000));
            endcase
            add_scans(190);
            drain();
        end

        $display("points sent %0d, goals checked %0d (%0d with a point found)",
                 points_sent, goals_seen, found_seen);
        $display("covered register extremes, wrapped targets, empty windows and four idle patterns");
        if (mismatches == 0 && expected_goals.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/npis_pkg.sv
rtl/npis_cfg.sv
rtl/npis_ctrl.sv
rtl/npis_datapath.sv
rtl/nearest_point_in_sector_unit.sv
dv/tb_nearest_point_in_sector_unit.sv
